// ===== rtl/i2c_master_bit_sequencer_core_defines.svh =====
// Assertion macros for the I2C master bit sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define I2CBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2cbs assertion failed");

`define I2CBS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("i2cbs assertion failed");

`else

`define I2CBS_ASSERT(label, prop)

`define I2CBS_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/i2cbs_pkg.sv =====
package i2cbs_pkg;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_START_HOLD = 5'd1,
    PH_START_TAIL = 5'd2,
    PH_WR_SETUP   = 5'd3,
    PH_WR_RISE    = 5'd4,
    PH_WR_HIGH    = 5'd5,
    PH_WR_LOW     = 5'd6,
    PH_ACK_RISE   = 5'd7,
    PH_ACK_SAMPLE = 5'd8,
    PH_ACK_HIGH   = 5'd9,
    PH_TAIL       = 5'd10,
    PH_RD_RISE    = 5'd11,
    PH_RD_HIGH    = 5'd12,
    PH_RD_LOW     = 5'd13,
    PH_RA_RISE    = 5'd14,
    PH_RA_HIGH    = 5'd15,
    PH_STOP_PRE   = 5'd16,
    PH_STOP_RISE  = 5'd17,
    PH_STOP_HOLD  = 5'd18
  } phase_t;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_WRITE = 2'd1,
    FN_READ  = 2'd2,
    FN_STOP  = 2'd3
  } func_t;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_STOP_DELAY  = 2'd1;
  localparam logic [1:0] CFG_ACK_SAMPLE  = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [15:0] STOP_DELAY_RESET  = 16'd100;
  localparam logic [15:0] ACK_SAMPLE_RESET  = 16'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_data;
  } res_t;

endpackage

// ===== rtl/i2c_master_bit_sequencer_core.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready   | cmd_valid func target_address read_not_write
//         |                       | write_data last_byte scl_in sda_in
// out     | out_valid / out_ready | scl_drive_low sda_drive_low busy_res done_res
//         |                       | ack_received read_data
// cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One word in, one word out; a word is taken each cycle that in_ready is high;
// its result is registered in out_word, or in the skid stage on a stall.
// Reset (rst, synchronous) idles the sequencer, clears both line-drive flags and
// loads the delay registers with their defaults.
// A stalled result moves to a one-word skid stage; in_ready drops only
// while that stage is full. cfg_ready is always high.
`include "i2c_master_bit_sequencer_core_defines.svh"

module i2c_master_bit_sequencer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd_valid,
  input  logic [1:0]           func,
  input  logic [6:0]           target_address,
  input  logic                 read_not_write,
  input  logic [7:0]           write_data,
  input  logic                 last_byte,
  input  logic                 scl_in,
  input  logic                 sda_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_drive_low,
  output logic                 sda_drive_low,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 ack_received,
  output logic [7:0]           read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import i2cbs_pkg::*;

  logic [15:0] half_period_ticks;
  logic [15:0] stop_delay_ticks;
  logic [15:0] ack_sample_ticks;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] wait_count, wait_count_next;
  logic        scl_low_flag, scl_low_flag_next;
  logic        sda_low_flag, sda_low_flag_next;
  logic        ack_flag, ack_flag_next;
  logic        nack_on_read, nack_on_read_next;
  logic [7:0]  read_hold, read_hold_next;
  logic        done;
  logic        delay_over;

  res_t        res_word;
  res_t        out_word;
  res_t        skid_word;
  logic        skid_valid;
  logic        in_take;
  logic        out_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      stop_delay_ticks  <= STOP_DELAY_RESET;
      ack_sample_ticks  <= ACK_SAMPLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        CFG_STOP_DELAY:  stop_delay_ticks  <= cfg_data;
        CFG_ACK_SAMPLE:  ack_sample_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign delay_over = (wait_count <= 16'd1);

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    wait_count_next   = delay_over ? wait_count : wait_count - 16'd1;
    scl_low_flag_next = scl_low_flag;
    sda_low_flag_next = sda_low_flag;
    ack_flag_next     = ack_flag;
    nack_on_read_next = nack_on_read;
    read_hold_next    = read_hold;
    done              = 1'b0;
    case (phase)
      PH_IDLE: begin
        wait_count_next = wait_count;
        if (cmd_valid) begin
          case (func_t'(func))
            FN_START: begin
              shift_byte_next   = {target_address, read_not_write};
              sda_low_flag_next = 1'b1;
              wait_count_next   = half_period_ticks;
              phase_next        = PH_START_HOLD;
            end
            FN_WRITE: begin
              shift_byte_next   = write_data;
              bit_count_next    = 4'd0;
              sda_low_flag_next = !write_data[7];
              wait_count_next   = half_period_ticks;
              phase_next        = PH_WR_SETUP;
            end
            FN_READ: begin
              nack_on_read_next = last_byte;
              shift_byte_next   = 8'd0;
              bit_count_next    = 4'd0;
              sda_low_flag_next = 1'b0;
              scl_low_flag_next = 1'b0;
              phase_next        = PH_RD_RISE;
            end
            default: begin
              sda_low_flag_next = 1'b1;
              wait_count_next   = stop_delay_ticks;
              phase_next        = PH_STOP_PRE;
            end
          endcase
        end
      end
      PH_START_HOLD: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b1;
          wait_count_next   = half_period_ticks;
          phase_next        = PH_START_TAIL;
        end
      end
      PH_START_TAIL: begin
        if (delay_over) begin
          bit_count_next    = 4'd0;
          sda_low_flag_next = !shift_byte[7];
          wait_count_next   = half_period_ticks;
          phase_next        = PH_WR_SETUP;
        end
      end
      PH_WR_SETUP: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b0;
          phase_next        = PH_WR_RISE;
        end
      end
      PH_WR_RISE: begin
        wait_count_next = wait_count;
        if (scl_in) begin
          wait_count_next = half_period_ticks;
          phase_next      = PH_WR_HIGH;
        end
      end
      PH_WR_HIGH: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b1;
          shift_byte_next   = {shift_byte[6:0], 1'b0};
          bit_count_next    = bit_count + 4'd1;
          wait_count_next   = half_period_ticks;
          phase_next        = PH_WR_LOW;
        end
      end
      PH_WR_LOW: begin
        if (delay_over) begin
          if (bit_count < BITS_PER_BYTE) begin
            sda_low_flag_next = !shift_byte[7];
            wait_count_next   = half_period_ticks;
            phase_next        = PH_WR_SETUP;
          end else begin
            sda_low_flag_next = 1'b0;
            scl_low_flag_next = 1'b0;
            phase_next        = PH_ACK_RISE;
          end
        end
      end
      PH_ACK_RISE: begin
        wait_count_next = wait_count;
        if (scl_in) begin
          wait_count_next = ack_sample_ticks;
          phase_next      = PH_ACK_SAMPLE;
        end
      end
      PH_ACK_SAMPLE: begin
        if (delay_over) begin
          if (sda_in) begin
            ack_flag_next = 1'b0;
            phase_next    = PH_IDLE;
            done          = 1'b1;
          end else begin
            ack_flag_next   = 1'b1;
            wait_count_next = half_period_ticks;
            phase_next      = PH_ACK_HIGH;
          end
        end
      end
      PH_ACK_HIGH: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b1;
          wait_count_next   = half_period_ticks;
          phase_next        = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (delay_over) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_RD_RISE: begin
        wait_count_next = wait_count;
        if (scl_in) begin
          shift_byte_next = {shift_byte[6:0], sda_in};
          wait_count_next = half_period_ticks;
          phase_next      = PH_RD_HIGH;
        end
      end
      PH_RD_HIGH: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b1;
          bit_count_next    = bit_count + 4'd1;
          wait_count_next   = half_period_ticks;
          phase_next        = PH_RD_LOW;
        end
      end
      PH_RD_LOW: begin
        if (delay_over) begin
          if (bit_count >= BITS_PER_BYTE) begin
            read_hold_next    = shift_byte;
            sda_low_flag_next = !nack_on_read;
            phase_next        = PH_RA_RISE;
          end else begin
            phase_next = PH_RD_RISE;
          end
          scl_low_flag_next = 1'b0;
        end
      end
      PH_RA_RISE: begin
        wait_count_next = wait_count;
        if (scl_in) begin
          wait_count_next = half_period_ticks;
          phase_next      = PH_RA_HIGH;
        end
      end
      PH_RA_HIGH: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b1;
          sda_low_flag_next = 1'b0;
          wait_count_next   = half_period_ticks;
          phase_next        = PH_TAIL;
        end
      end
      PH_STOP_PRE: begin
        if (delay_over) begin
          scl_low_flag_next = 1'b0;
          phase_next        = PH_STOP_RISE;
        end
      end
      PH_STOP_RISE: begin
        wait_count_next = wait_count;
        if (scl_in) begin
          wait_count_next = stop_delay_ticks;
          phase_next      = PH_STOP_HOLD;
        end
      end
      PH_STOP_HOLD: begin
        if (delay_over) begin
          sda_low_flag_next = 1'b0;
          phase_next        = PH_IDLE;
          done              = 1'b1;
        end
      end
      default: begin
        wait_count_next = wait_count;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_word.scl_drive_low = scl_low_flag_next;
    res_word.sda_drive_low = sda_low_flag_next;
    res_word.busy_res      = (phase_next != PH_IDLE);
    res_word.done_res      = done;
    res_word.ack_received  = ack_flag_next;
    res_word.read_data     = read_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= 4'd0;
      shift_byte   <= 8'd0;
      wait_count   <= 16'd0;
      scl_low_flag <= 1'b0;
      sda_low_flag <= 1'b0;
      ack_flag     <= 1'b0;
      nack_on_read <= 1'b0;
      read_hold    <= 8'd0;
    end else if (in_take) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      wait_count   <= wait_count_next;
      scl_low_flag <= scl_low_flag_next;
      sda_low_flag <= sda_low_flag_next;
      ack_flag     <= ack_flag_next;
      nack_on_read <= nack_on_read_next;
      read_hold    <= read_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_take;
      end else begin
        out_valid  <= in_take;
      end
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (in_take) begin
          skid_word <= res_word;
        end
      end else if (in_take) begin
        out_word <= res_word;
      end
    end else if (in_take) begin
      skid_word <= res_word;
    end
  end

  assign scl_drive_low = out_word.scl_drive_low;
  assign sda_drive_low = out_word.sda_drive_low;
  assign busy_res      = out_word.busy_res;
  assign done_res      = out_word.done_res;
  assign ack_received  = out_word.ack_received;
  assign read_data     = out_word.read_data;

  `I2CBS_ASSERT_ALWAYS(a_skid_needs_out, skid_valid |-> out_valid)
  `I2CBS_ASSERT(a_done_not_busy, (out_valid && out_word.done_res) |-> !out_word.busy_res)
  `I2CBS_ASSERT(a_bit_count_range, bit_count <= BITS_PER_BYTE)
  `I2CBS_ASSERT(a_idle_holds, (in_take && phase == PH_IDLE && !cmd_valid) |=> phase == PH_IDLE)

endmodule
